>>> rtl/tick_priority_scheduler_semaphores_assert.svh
// assertion macros for the scheduler checker
`ifndef TICK_PRIORITY_SCHEDULER_SEMAPHORES_ASSERT_SVH
`define TICK_PRIORITY_SCHEDULER_SEMAPHORES_ASSERT_SVH
// implication checked on every clock edge outside reset
`define TPS_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define TPS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> rtl/tps_pkg.sv
// shared types and constants for the tick priority scheduler
package tps_pkg;
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_SCHED = 3'd1;
    localparam logic [2:0] FUNC_SLEEP = 3'd2;
    localparam logic [2:0] FUNC_P     = 3'd3;
    localparam logic [2:0] FUNC_V     = 3'd4;

    // result of one pass of the scan unit
    typedef struct packed {
        logic       found;
        logic [1:0] who;
    } scan_res_t;
endpackage

>>> rtl/tps_scan.sv
// shared compare unit: walks the tasks one a cycle and keeps the best
module tps_scan #(
    parameter int NUM_TASKS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [4*8-1:0]      ticks,
    input  logic [3:0]          eligible,
    output logic                done,
    output tps_pkg::scan_res_t  res
);
    logic       run_reg;
    logic [1:0] idx_reg;
    logic [7:0] best_reg;
    logic       found_reg;
    logic [1:0] who_reg;
    logic [7:0] cand;
    logic       better;

    // one compare per cycle
    assign cand   = ticks[idx_reg*8 +: 8];
    assign better = eligible[idx_reg] && (cand > best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            idx_reg   <= '0;
            best_reg  <= '0;
            found_reg <= 1'b0;
            who_reg   <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                run_reg   <= 1'b1;
                idx_reg   <= '0;
                best_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (run_reg)
            begin
                if (better)
                begin
                    best_reg  <= cand;
                    who_reg   <= idx_reg;
                    found_reg <= 1'b1;
                end
                if (idx_reg == 2'(NUM_TASKS - 1))
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    assign res.found = found_reg;
    assign res.who   = who_reg;
endmodule

>>> rtl/tick_priority_scheduler_semaphores.sv
// Scheduler with counting semaphores. An item is accepted when start is high
// and busy low; its result appears for one cycle with done. Tick, schedule,
// sleep and a blocking P go from S_OP to S_SCAN1 and then to S_OUT, which
// raises done; when no eligible task has ticks, a refill forces a second walk
// in S_SCAN2 first. The shared scan unit, started by a one-cycle go pulse,
// walks the tasks one per cycle. Non-blocking P, V and unused codes go from
// S_OP straight to S_OUT. busy drops with done, so the next item can be
// accepted while done is high. The receiver cannot stall results.
module tick_priority_scheduler_semaphores #(
    parameter int NUM_TASKS = 4,
    parameter int NUM_SEMS  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        func,
    input  logic [15:0]       sleep_ms,
    input  logic [1:0]        sem_index,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output logic              done,
    output logic [1:0]        running_task,
    output logic              none_ready,
    output logic              caller_blocked,
    output logic              woke_valid,
    output logic [1:0]        woken_task,
    output logic signed [7:0] sem_count_after
);
    typedef enum logic [2:0] {S_IDLE, S_OP, S_SCAN1, S_SCAN2, S_OUT} state_t;

    state_t            state_reg;
    logic [7:0]        prio_reg  [4];
    logic [7:0]        ticks_reg [4];
    logic [12:0]       sleep_reg [4];
    logic [3:0]        wait_reg;
    logic [1:0]        cur_reg;
    logic signed [7:0] cnt_reg   [4];
    logic [1:0]        ring_mem  [16];
    logic [1:0]        head_reg  [4];
    logic [1:0]        tail_reg  [4];
    logic [2:0]        func_reg;
    logic [15:0]       ms_reg;
    logic [1:0]        sem_reg;
    logic              go;
    logic              scan_done;
    tps_pkg::scan_res_t scan_res;
    logic [4*8-1:0]    ticks_flat;
    logic [3:0]        elig;
    logic [12:0]       div10;
    logic [31:0]       mul_prod;
    logic signed [7:0] cnt_cur;
    logic signed [7:0] cnt_dec;
    logic signed [7:0] cnt_inc;
    logic [1:0]        head_nx;
    logic [1:0]        tail_nx;
    logic [1:0]        ring_rd;

    // flatten tick counts and eligibility for the scan unit
    always_comb
    begin
        for (int t = 0; t < 4; t++)
        begin
            ticks_flat[t*8 +: 8] = ticks_reg[t];
            elig[t] = (t < NUM_TASKS) && (sleep_reg[t] == 13'd0) && !wait_reg[t];
        end
    end

    // ms / 10 as multiply by reciprocal
    assign mul_prod = 32'(ms_reg) * 32'd52429;
    assign div10    = mul_prod[31:19];

    assign cnt_cur = cnt_reg[sem_reg];
    assign cnt_dec = (cnt_cur == -8'sd128) ? cnt_cur : cnt_cur - 8'sd1;
    assign cnt_inc = (cnt_cur == 8'sd127) ? cnt_cur : cnt_cur + 8'sd1;
    assign head_nx = (head_reg[sem_reg] == 2'(NUM_TASKS - 1)) ? 2'd0
                                                              : head_reg[sem_reg] + 2'd1;
    assign tail_nx = (tail_reg[sem_reg] == 2'(NUM_TASKS - 1)) ? 2'd0
                                                              : tail_reg[sem_reg] + 2'd1;
    assign ring_rd = ring_mem[{sem_reg, tail_reg[sem_reg]}];
    assign busy    = (state_reg != S_IDLE);

    tps_scan #(.NUM_TASKS(NUM_TASKS)) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .ticks    (ticks_flat),
        .eligible (elig),
        .done     (scan_done),
        .res      (scan_res)
    );

    // ring storage, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OP && func_reg == tps_pkg::FUNC_P
            && 32'(sem_reg) < NUM_SEMS && cnt_dec < 0)
        begin
            ring_mem[{sem_reg, head_reg[sem_reg]}] <= cur_reg;
        end
    end

    // sequencer and task state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            prio_reg[0]     <= 8'd15;
            prio_reg[1]     <= 8'd5;
            prio_reg[2]     <= 8'd5;
            prio_reg[3]     <= 8'd5;
            for (int i = 0; i < 4; i++)
            begin
                ticks_reg[i] <= '0;
                sleep_reg[i] <= '0;
                cnt_reg[i]   <= 8'sd1;
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
            end
            wait_reg        <= '0;
            cur_reg         <= '0;
            go              <= 1'b0;
            done            <= 1'b0;
            running_task    <= '0;
            none_ready      <= 1'b0;
            caller_blocked  <= 1'b0;
            woke_valid      <= 1'b0;
            woken_task      <= '0;
            sem_count_after <= '0;
            func_reg        <= '0;
            ms_reg          <= '0;
            sem_reg         <= '0;
        end
        else
        begin
            go   <= 1'b0;
            done <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index[2])
                    cnt_reg[cfg_index[1:0]] <= signed'({1'b0, cfg_data[6:0]});
                else
                    prio_reg[cfg_index[1:0]] <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        func_reg        <= func;
                        ms_reg          <= sleep_ms;
                        sem_reg         <= sem_index;
                        none_ready      <= 1'b0;
                        caller_blocked  <= 1'b0;
                        woke_valid      <= 1'b0;
                        woken_task      <= '0;
                        sem_count_after <= '0;
                        state_reg       <= S_OP;
                    end
                end
                S_OP:
                begin
                    state_reg <= S_OUT;
                    case (func_reg)
                        tps_pkg::FUNC_TICK:
                        begin
                            for (int i = 0; i < 4; i++)
                                if (sleep_reg[i] != 13'd0)
                                    sleep_reg[i] <= sleep_reg[i] - 13'd1;
                            if (ticks_reg[cur_reg] != 8'd0)
                                ticks_reg[cur_reg] <= ticks_reg[cur_reg] - 8'd1;
                            go        <= 1'b1;
                            state_reg <= S_SCAN1;
                        end
                        tps_pkg::FUNC_SCHED:
                        begin
                            go        <= 1'b1;
                            state_reg <= S_SCAN1;
                        end
                        tps_pkg::FUNC_SLEEP:
                        begin
                            sleep_reg[cur_reg] <= div10;
                            go                 <= 1'b1;
                            state_reg          <= S_SCAN1;
                        end
                        tps_pkg::FUNC_P:
                        begin
                            if (32'(sem_reg) < NUM_SEMS)
                            begin
                                cnt_reg[sem_reg]  <= cnt_dec;
                                sem_count_after   <= cnt_dec;
                                if (cnt_dec < 0)
                                begin
                                    wait_reg[cur_reg] <= 1'b1;
                                    head_reg[sem_reg] <= head_nx;
                                    caller_blocked    <= 1'b1;
                                    go                <= 1'b1;
                                    state_reg         <= S_SCAN1;
                                end
                            end
                        end
                        tps_pkg::FUNC_V:
                        begin
                            if (32'(sem_reg) < NUM_SEMS)
                            begin
                                cnt_reg[sem_reg] <= cnt_inc;
                                sem_count_after  <= cnt_inc;
                                if (cnt_inc <= 0)
                                begin
                                    if (32'(ring_rd) < NUM_TASKS)
                                        wait_reg[ring_rd] <= 1'b0;
                                    tail_reg[sem_reg] <= tail_nx;
                                    woke_valid        <= 1'b1;
                                    woken_task        <= ring_rd;
                                end
                            end
                        end
                        default:
                        begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_SCAN1:
                begin
                    if (scan_done)
                    begin
                        if (scan_res.found)
                        begin
                            cur_reg   <= scan_res.who;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            // refill every task and walk again
                            for (int i = 0; i < 4; i++)
                                if (i < NUM_TASKS)
                                    ticks_reg[i] <= prio_reg[i];
                            go        <= 1'b1;
                            state_reg <= S_SCAN2;
                        end
                    end
                end
                S_SCAN2:
                begin
                    if (scan_done)
                    begin
                        if (scan_res.found)
                            cur_reg <= scan_res.who;
                        else
                            none_ready <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    running_task <= cur_reg;
                    done         <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

>>> rtl/tps_checker.sv
// port-level checker for the scheduler, bound to the top level
`include "tick_priority_scheduler_semaphores_assert.svh"
module tps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       caller_blocked,
    input logic       woke_valid,
    input logic       none_ready,
    input logic [1:0] woken_task
);
    `TPS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `TPS_ASSERT_IMPL(a_done_flags, clk, rst_n, done, !(caller_blocked && woke_valid))
    `TPS_ASSERT_IMPL(a_woken_zero, clk, rst_n, done && !woke_valid, woken_task == 2'd0)
    `TPS_ASSERT_IMPL(a_none_blk, clk, rst_n, done && woke_valid, !none_ready)
endmodule

bind tick_priority_scheduler_semaphores tps_checker u_tps_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .caller_blocked (caller_blocked),
    .woke_valid     (woke_valid),
    .none_ready     (none_ready),
    .woken_task     (woken_task)
);

>>> dv/tick_priority_scheduler_semaphores_test.sv
// self-checking testbench for the tick priority scheduler with counting semaphores
`timescale 1ns / 100ps

module tick_priority_scheduler_semaphores_test;

    // unused operation codes
    localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    // register indexes
    localparam logic [2:0] REG_TASK0_PRIO = 3'd0;
    localparam logic [2:0] REG_SEM0_INIT  = 3'd4;
    localparam int NUM_REGS = 8;

    localparam int PHASE_ITEMS = 160;
    localparam int SETTLE_CYCLES = 15;

    typedef struct packed {
        logic [1:0]        running;
        logic              none;
        logic              blocked;
        logic              woke;
        logic [1:0]        woken;
        logic signed [7:0] count;
    } sched_result_t;

    typedef struct {
        logic [2:0]    op;
        logic [15:0]   ms;
        logic [1:0]    sem;
        bit            typed;
        sched_result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] func;
    logic [15:0] sleep_ms;
    logic [1:0] sem_index;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    logic done;
    logic [1:0] running_task;
    logic none_ready;
    logic caller_blocked;
    logic woke_valid;
    logic [1:0] woken_task;
    logic signed [7:0] sem_count_after;

    tick_priority_scheduler_semaphores dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .sleep_ms(sleep_ms),
        .sem_index(sem_index),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .done(done),
        .running_task(running_task),
        .none_ready(none_ready),
        .caller_blocked(caller_blocked),
        .woke_valid(woke_valid),
        .woken_task(woken_task),
        .sem_count_after(sem_count_after)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // scheduler state as the testbench sees it
    logic [7:0] prio_cfg [4];
    logic [7:0] ticks_left [4];
    int         sleep_cnt [4];
    bit         is_waiting [4];
    logic [1:0] cur_task;
    int         sem_cnt [4];
    logic [1:0] wait_ring [4][4];
    bit         ring_valid [4][4];
    logic [1:0] ring_wr [4];
    logic [1:0] ring_rd [4];

    sched_result_t expected_results [$];
    int errors;

    // eligible task with the most ticks, lowest index on ties
    function automatic int best_task();
        int best;
        int who;
        best = 0;
        who = -1;
        for (int t = 0; t < 4; t++)
        begin
            if (sleep_cnt[t] == 0 && !is_waiting[t] && ticks_left[t] > best)
            begin
                best = ticks_left[t];
                who = t;
            end
        end
        return who;
    endfunction

    // returns 1 when nothing could run even after a refill
    function automatic bit reschedule();
        int who;
        who = best_task();
        if (who < 0)
        begin
            for (int t = 0; t < 4; t++)
                ticks_left[t] = prio_cfg[t];
            who = best_task();
        end
        if (who < 0)
            return 1'b1;
        cur_task = who[1:0];
        return 1'b0;
    endfunction

    function automatic sched_result_t predict_syscall(logic [2:0] op, logic [15:0] ms,
                                                      logic [1:0] s);
        sched_result_t r;
        logic [1:0] caller;
        r = '0;
        caller = cur_task;
        case (op)
            tps_pkg::FUNC_TICK:
            begin
                for (int t = 0; t < 4; t++)
                    if (sleep_cnt[t] != 0)
                        sleep_cnt[t]--;
                if (ticks_left[caller] != 0)
                    ticks_left[caller]--;
                r.none = reschedule();
            end
            tps_pkg::FUNC_SCHED:
                r.none = reschedule();
            tps_pkg::FUNC_SLEEP:
            begin
                sleep_cnt[caller] = ms / 10;
                r.none = reschedule();
            end
            tps_pkg::FUNC_P:
            begin
                if (sem_cnt[s] > -128)
                    sem_cnt[s]--;
                if (sem_cnt[s] < 0)
                begin
                    is_waiting[caller] = 1'b1;
                    wait_ring[s][ring_wr[s]] = caller;
                    ring_valid[s][ring_wr[s]] = 1'b1;
                    ring_wr[s] = ring_wr[s] + 2'd1;
                    r.blocked = 1'b1;
                    r.none = reschedule();
                end
                r.count = sem_cnt[s][7:0];
            end
            tps_pkg::FUNC_V:
            begin
                if (sem_cnt[s] < 127)
                    sem_cnt[s]++;
                if (sem_cnt[s] <= 0)
                begin
                    r.woken = wait_ring[s][ring_rd[s]];
                    is_waiting[r.woken] = 1'b0;
                    ring_rd[s] = ring_rd[s] + 2'd1;
                    r.woke = 1'b1;
                end
                r.count = sem_cnt[s][7:0];
            end
            default:
                ;
        endcase
        r.running = cur_task;
        return r;
    endfunction

    // a release from a ring slot that was never filled is kept out of the stimulus
    function automatic bit release_unfilled(logic [1:0] s);
        int next_cnt;
        next_cnt = (sem_cnt[s] < 127) ? sem_cnt[s] + 1 : sem_cnt[s];
        return next_cnt <= 0 && !ring_valid[s][ring_rd[s]];
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // result check, sampled mid-cycle
    always @(negedge clk)
    begin
        sched_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transfer, expected none, actual task %0d",
                         $time, running_task);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("running_task", want.running, running_task);
                check_field("none_ready", want.none, none_ready);
                check_field("caller_blocked", want.blocked, caller_blocked);
                check_field("woke_valid", want.woke, woke_valid);
                check_field("woken_task", want.woken, woken_task);
                check_field("sem_count_after", want.count, sem_count_after);
            end
        end
    end

    // write all registers back to back, block idle
    task automatic write_config(logic [7:0] vals [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= vals[i];
            if (i < REG_SEM0_INIT)
                prio_cfg[i - REG_TASK0_PRIO] = vals[i];
            else
                sem_cnt[i - REG_SEM0_INIT] = vals[i][6:0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one command transfer, called and returning at a rising edge
    task automatic send_item(logic [2:0] op, logic [15:0] ms, logic [1:0] s,
                             bit typed, sched_result_t want);
        bit taken;
        sched_result_t got;
        start <= 1'b1;
        func <= op;
        sleep_ms <= ms;
        sem_index <= s;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            if (taken)
            begin
                got = predict_syscall(op, ms, s);
                expected_results.push_back(typed ? want : got);
            end
            @(posedge clk);
        end
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // sender holds off until every result is back
    task automatic drain();
        idle_gap(1);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random(bit no_gaps);
        int pick;
        logic [2:0] op;
        logic [15:0] ms;
        logic [1:0] s;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            op = tps_pkg::FUNC_TICK;
        else if (pick < 38)
            op = tps_pkg::FUNC_SCHED;
        else if (pick < 50)
            op = tps_pkg::FUNC_SLEEP;
        else if (pick < 70)
            op = tps_pkg::FUNC_P;
        else if (pick < 94)
            op = tps_pkg::FUNC_V;
        else
            op = 3'($urandom_range(FUNC_SPARE_5, FUNC_SPARE_7));
        ms = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        s = 2'($urandom_range(0, 3));
        if (op == tps_pkg::FUNC_V && release_unfilled(s))
            op = tps_pkg::FUNC_SCHED;
        send_item(op, ms, s, 1'b0, '0);
        idle_gap(no_gaps ? 0 : $urandom_range(0, 14));
    endtask

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        stim_row_t rows [$];
        logic [7:0] regs [NUM_REGS];
        bit no_gaps;

        errors = 0;
        rst_n = 1'b0;
        start = 1'b0;
        func = tps_pkg::FUNC_TICK;
        sleep_ms = '0;
        sem_index = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_task = '0;
        prio_cfg = '{8'd15, 8'd5, 8'd5, 8'd5};
        for (int i = 0; i < 4; i++)
        begin
            ticks_left[i] = '0;
            sleep_cnt[i] = 0;
            is_waiting[i] = 1'b0;
            sem_cnt[i] = 1;
            ring_wr[i] = '0;
            ring_rd[i] = '0;
            for (int j = 0; j < 4; j++)
            begin
                ring_valid[i][j] = 1'b0;
                wait_ring[i][j] = '0;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows from reset defaults
        rows = '{
            '{tps_pkg::FUNC_SCHED, 16'd0,    2'd0, 1'b1,
              '{2'd0, 1'b0, 1'b0, 1'b0, 2'd0, 8'sd0}},
            '{FUNC_SPARE_5,        16'd0,    2'd0, 1'b1,
              '{2'd0, 1'b0, 1'b0, 1'b0, 2'd0, 8'sd0}},
            '{FUNC_SPARE_7,        16'hffff, 2'd3, 1'b1,
              '{2'd0, 1'b0, 1'b0, 1'b0, 2'd0, 8'sd0}},
            '{tps_pkg::FUNC_P,     16'd0,    2'd2, 1'b1,
              '{2'd0, 1'b0, 1'b0, 1'b0, 2'd0, 8'sd0}},
            '{tps_pkg::FUNC_V,     16'd0,    2'd2, 1'b1,
              '{2'd0, 1'b0, 1'b0, 1'b0, 2'd0, 8'sd1}},
            '{tps_pkg::FUNC_TICK,  16'd0,    2'd0, 1'b0, '0},
            '{tps_pkg::FUNC_SLEEP, 16'hffff, 2'd0, 1'b0, '0},
            '{tps_pkg::FUNC_P,     16'd0,    2'd0, 1'b0, '0},
            '{tps_pkg::FUNC_P,     16'd0,    2'd0, 1'b0, '0},
            '{tps_pkg::FUNC_P,     16'd0,    2'd0, 1'b0, '0},
            '{tps_pkg::FUNC_V,     16'd0,    2'd0, 1'b0, '0},
            '{tps_pkg::FUNC_V,     16'd0,    2'd0, 1'b0, '0},
            '{tps_pkg::FUNC_V,     16'd0,    2'd0, 1'b0, '0},
            '{tps_pkg::FUNC_SLEEP, 16'd9,    2'd0, 1'b0, '0},
            '{tps_pkg::FUNC_TICK,  16'd0,    2'd0, 1'b0, '0},
            '{tps_pkg::FUNC_SLEEP, 16'd10,   2'd0, 1'b0, '0},
            '{tps_pkg::FUNC_TICK,  16'd0,    2'd0, 1'b0, '0},
            '{tps_pkg::FUNC_SCHED, 16'd0,    2'd0, 1'b0, '0},
            '{tps_pkg::FUNC_P,     16'd0,    2'd1, 1'b0, '0},
            '{tps_pkg::FUNC_P,     16'd0,    2'd1, 1'b0, '0},
            '{tps_pkg::FUNC_V,     16'd0,    2'd1, 1'b0, '0},
            '{tps_pkg::FUNC_SLEEP, 16'h8000, 2'd3, 1'b0, '0},
            '{FUNC_SPARE_6,        16'h5555, 2'd1, 1'b0, '0}
        };
        foreach (rows[i])
        begin
            send_item(rows[i].op, rows[i].ms, rows[i].sem, rows[i].typed, rows[i].want);
            idle_gap($urandom_range(0, 3));
        end
        drain();

        // phases: both extremes and one low fixed setting first, then random settings
        for (int phase = 0; phase < 7; phase++)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                case (phase)
                    0: regs[i] = (i < REG_SEM0_INIT) ? 8'd255 : 8'd127;
                    1: regs[i] = 8'd0;
                    2: regs[i] = (i < REG_SEM0_INIT) ? 8'd1 : 8'd0;
                    default: regs[i] = (i < REG_SEM0_INIT) ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range(0, 3));
                endcase
            end
            if (phase == 5)
                regs[REG_SEM0_INIT + 1] = 8'd127;
            write_config(regs);

            // long run of waits to drive a count down to its floor
            if (phase == 2)
            begin
                for (int i = 0; i < 130; i++)
                begin
                    send_item(tps_pkg::FUNC_P, 16'($urandom), 2'd3, 1'b0, '0);
                    idle_gap($urandom_range(0, 2));
                end
            end

            no_gaps = 1'b0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                send_random(no_gaps);
            end
            drain();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
